FILE: hdl/trp_pkg.sv
package trp_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int WIDTH_BITS_DEF    = 16;
  localparam int QUEUE_DEPTH       = 4;
  localparam int MIN_WIDTH         = 4;

  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;
  localparam logic [1:0] DEPTH_24 = 2'd2;
  localparam logic [1:0] DEPTH_32 = 2'd3;

  localparam logic [1:0] REG_DEPTH   = 2'd0;
  localparam logic [1:0] REG_RUN     = 2'd1;
  localparam logic [1:0] REG_PALETTE = 2'd2;
  localparam logic [1:0] REG_WIDTH   = 2'd3;

  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_DATA    = 1'b1;

  localparam logic [1:0]  RESET_DEPTH   = DEPTH_24;
  localparam logic        RESET_RUN     = 1'b1;
  localparam logic [8:0]  RESET_PALETTE = 9'd0;
  localparam logic [15:0] RESET_WIDTH   = 16'd640;

  typedef struct packed {
    logic [1:0]  depth_code;
    logic        run_coded;
    logic [8:0]  palette_entries;
    logic [15:0] image_width;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] count;
  } run_t;

endpackage

FILE: hdl/trp_front.sv
module trp_front
  import trp_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  palette_index,
  input  logic [23:0] palette_color,
  output logic        q_push,
  output run_t        q_data,
  input  logic        q_full
);

  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0] palette [PALETTE_DEPTH];

  logic        in_body;
  logic        is_repeat;
  logic [7:0]  remaining;
  logic [1:0]  byte_pos;
  logic [31:0] acc;

  logic        s1_valid;
  logic [31:0] s1_pixel;
  logic [7:0]  s1_count;
  logic [23:0] s1_pal;

  logic        accept;
  logic        header;
  logic        done;
  logic        finish;
  logic [31:0] pixel;
  logic [7:0]  count;
  logic [7:0]  rem_dec;
  logic [7:0]  v;

  assign full   = s1_valid && q_full;
  assign accept = push && !full;
  assign pixel  = acc | ({24'd0, data_byte} << {byte_pos, 3'b000});
  assign header = cfg.run_coded && !in_body;
  assign done   = !header && (byte_pos >= cfg.depth_code);
  assign finish = accept && mode == MODE_DATA && done;
  assign count  = (!cfg.run_coded || !is_repeat) ? 8'd1 : remaining;
  assign rem_dec = (remaining != 8'd0) ? remaining - 8'd1 : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body   <= 1'b0;
      is_repeat <= 1'b0;
      remaining <= 8'd0;
      byte_pos  <= 2'd0;
      acc       <= 32'd0;
      s1_valid  <= 1'b0;
    end else begin
      if (s1_valid && !q_full && !finish) begin
        s1_valid <= 1'b0;
      end
      if (accept && mode == MODE_DATA) begin
        if (header) begin
          is_repeat <= data_byte[7];
          remaining <= {1'b0, data_byte[6:0]} + 8'd1;
          in_body   <= 1'b1;
          byte_pos  <= 2'd0;
          acc       <= 32'd0;
        end else if (!done) begin
          byte_pos <= byte_pos + 2'd1;
          acc      <= pixel;
        end else begin
          byte_pos <= 2'd0;
          acc      <= 32'd0;
          s1_valid <= (count != 8'd0);
          if (cfg.run_coded) begin
            if (is_repeat) begin
              remaining <= 8'd0;
              in_body   <= 1'b0;
            end else begin
              remaining <= rem_dec;
              if (rem_dec == 8'd0) begin
                in_body <= 1'b0;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      s1_pixel <= pixel;
      s1_count <= count;
      s1_pal   <= palette[pixel[PAL_AW-1:0]];
    end
    if (accept && mode == MODE_PALETTE && {1'b0, palette_index} < 9'(PALETTE_DEPTH)) begin
      palette[palette_index[PAL_AW-1:0]] <= palette_color;
    end
  end

  assign v = s1_pixel[7:0];

  always_comb begin
    q_data.count = s1_count;
    q_data.alpha = 8'd255;
    unique case (cfg.depth_code)
      DEPTH_8: begin
        if (cfg.palette_entries == 9'd0) begin
          q_data.red   = v;
          q_data.green = v;
          q_data.blue  = v;
        end else if ({1'b0, v} < cfg.palette_entries && {1'b0, v} < 9'(PALETTE_DEPTH)) begin
          q_data.red   = s1_pal[23:16];
          q_data.green = s1_pal[15:8];
          q_data.blue  = s1_pal[7:0];
        end else begin
          q_data.red   = 8'd0;
          q_data.green = 8'd0;
          q_data.blue  = 8'd0;
          q_data.alpha = 8'd0;
        end
      end
      DEPTH_16: begin
        q_data.red   = {s1_pixel[14:10], 3'b000};
        q_data.green = {s1_pixel[9:5], 3'b000};
        q_data.blue  = {s1_pixel[4:0], 3'b000};
      end
      DEPTH_24: begin
        q_data.red   = s1_pixel[23:16];
        q_data.green = s1_pixel[15:8];
        q_data.blue  = s1_pixel[7:0];
      end
      default: begin
        q_data.red   = s1_pixel[23:16];
        q_data.green = s1_pixel[15:8];
        q_data.blue  = s1_pixel[7:0];
        q_data.alpha = s1_pixel[31:24];
      end
    endcase
  end

  assign q_push = s1_valid && !q_full;

  a_body_has_pixels: assert property (@(posedge clk) disable iff (rst)
    in_body |-> remaining != 8'd0)
    else $error("packet body with no pixels left");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && q_full |=> s1_valid && $stable(s1_pixel) && $stable(s1_count))
    else $error("stalled pixel lost or changed");

  a_nonzero_run: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> s1_count != 8'd0)
    else $error("empty run staged");

endmodule

FILE: hdl/trp_queue.sv
module trp_queue
  import trp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  run_t push_data,
  output logic full,
  input  logic pop,
  output run_t head,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> !empty)
    else $error("queue empty after push");

endmodule

FILE: hdl/trp_back.sv
module trp_back
  import trp_pkg::*;
#(
  parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  run_t       head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] alpha,
  output logic [7:0] run_length,
  output logic       row_end,
  output logic       last,
  output logic       empty,
  input  logic       pop
);

  localparam int WB = WIDTH_BITS;

  logic [WB-1:0] col;
  logic          busy;
  logic [7:0]    rem;
  run_t          cur;
  logic          out_valid;

  logic [WB-1:0] w_raw;
  logic [WB-1:0] row_w;
  logic [WB-1:0] col_eff;
  logic [WB-1:0] space;
  logic [7:0]    src_count;
  logic [WB-1:0] cnt_ext;
  logic          take_all;
  logic          end_n;
  logic [7:0]    piece;
  logic [WB-1:0] col_next;
  run_t          src;
  logic          load;
  logic          have_src;
  logic          fire;

  assign w_raw     = cfg.image_width[WB-1:0];
  assign row_w     = (w_raw < WB'(MIN_WIDTH)) ? WB'(MIN_WIDTH) : w_raw;
  assign col_eff   = (col < row_w) ? col : '0;
  assign space     = row_w - col_eff;
  assign src       = busy ? cur : head;
  assign src_count = busy ? rem : head.count;
  assign cnt_ext   = WB'(src_count);
  assign take_all  = (cnt_ext <= space);
  assign end_n     = (cnt_ext >= space);
  assign piece     = take_all ? src_count : space[7:0];
  assign col_next  = end_n ? '0 : col_eff + WB'(piece);

  assign load     = !out_valid || pop;
  assign have_src = busy || !q_empty;
  assign fire     = load && have_src;
  assign q_pop    = fire && !busy;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= have_src;
      end
      if (fire) begin
        col  <= col_next;
        busy <= !take_all;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      red        <= src.red;
      green      <= src.green;
      blue       <= src.blue;
      alpha      <= src.alpha;
      run_length <= piece;
      row_end    <= end_n;
      last       <= take_all;
      rem        <= src_count - piece;
      if (!busy) begin
        cur <= head;
      end
    end
  end

  a_split_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> busy)
    else $error("split run without remainder");

  a_row_end_wraps: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_end |-> col == '0)
    else $error("row end without column wrap");

  a_busy_has_rest: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem != 8'd0)
    else $error("busy with nothing left");

endmodule

FILE: hdl/tga_rle_pixel_decoder_top.sv
// Channel   Ports                                           Handshake
// config    psel penable pwrite paddr pwdata prdata pready  write at psel&penable&pwrite
// input     mode data_byte palette_index palette_color      push & !full
// result    red green blue alpha run_length row_end last    pop & !empty
//
// One input item per cycle while full is low; a finished pixel is staged, queued and registered.
// A run crossing row ends leaves as one item per row piece, one per cycle while pop is held.
// Synchronous reset clears packet, pixel, column and queue state; palette stays undefined.
// full rises only while the staged pixel waits on a full run queue; the back stalls
// on pop alone.
module tga_rle_pixel_decoder_top
  import trp_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int WIDTH_BITS    = WIDTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  palette_index,
  input  logic [23:0] palette_color,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [7:0]  run_length,
  output logic        row_end,
  output logic        last,
  output logic        empty,
  input  logic        pop
);

  cfg_t cfg;
  logic q_push;
  run_t q_data;
  logic q_full;
  run_t q_head;
  logic q_empty;
  logic q_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_code      <= RESET_DEPTH;
      cfg.run_coded       <= RESET_RUN;
      cfg.palette_entries <= RESET_PALETTE;
      cfg.image_width     <= RESET_WIDTH;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_DEPTH:   cfg.depth_code      <= pwdata[1:0];
        REG_RUN:     cfg.run_coded       <= pwdata[0];
        REG_PALETTE: cfg.palette_entries <= pwdata[8:0];
        default:     cfg.image_width     <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEPTH:   prdata = {30'd0, cfg.depth_code};
      REG_RUN:     prdata = {31'd0, cfg.run_coded};
      REG_PALETTE: prdata = {23'd0, cfg.palette_entries};
      default:     prdata = {16'd0, cfg.image_width};
    endcase
  end

  trp_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .data_byte    (data_byte),
    .palette_index(palette_index),
    .palette_color(palette_color),
    .q_push       (q_push),
    .q_data       (q_data),
    .q_full       (q_full)
  );

  trp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_data),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  trp_back #(
    .WIDTH_BITS(WIDTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .run_length(run_length),
    .row_end   (row_end),
    .last      (last),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

FILE: tb/tga_rle_pixel_decoder_checker.sv
module tga_rle_pixel_decoder_checker
  import trp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        push,
  input  logic        full,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  palette_index,
  input  logic [23:0] palette_color,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  input  logic [7:0]  run_length,
  input  logic        row_end,
  input  logic        last,
  input  logic        empty,
  input  logic        pop,
  output int          fails,
  output int          checked,
  output int          pending,
  output logic        aligned
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] run_length;
    logic       row_end;
    logic       last;
  } piece_t;

  cfg_t        cfg;
  logic        in_body;
  logic        repeat_run;
  logic [7:0]  pixels_left;
  logic [1:0]  byte_pos;
  logic [31:0] pixel_acc;
  logic [15:0] column;
  logic [23:0] palette_copy [PALETTE_DEPTH_DEF];
  piece_t      expected_pieces [$];

  function automatic logic [31:0] to_rgba(logic [31:0] p);
    logic [7:0] v;
    v = p[7:0];
    case (cfg.depth_code)
      DEPTH_8: begin
        if (cfg.palette_entries == 0) return {v, v, v, 8'hFF};
        if (v < cfg.palette_entries) return {palette_copy[v], 8'hFF};
        return '0;
      end
      DEPTH_16: return {p[14:10], 3'b000, p[9:5], 3'b000, p[4:0], 3'b000, 8'hFF};
      DEPTH_24: return {p[23:0], 8'hFF};
      default:  return {p[23:0], p[31:24]};
    endcase
  endfunction

  task automatic split_run(logic [31:0] rgba, int count);
    int     w;
    int     col;
    int     space;
    int     piece;
    piece_t e;
    w = cfg.image_width;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    while (count > 0) begin
      col = (column < w) ? column : 0;
      space = w - col;
      piece = (count < space) ? count : space;
      e.red = rgba[31:24];
      e.green = rgba[23:16];
      e.blue = rgba[15:8];
      e.alpha = rgba[7:0];
      e.run_length = piece[7:0];
      e.row_end = (col + piece == w);
      e.last = (piece == count);
      column = e.row_end ? 16'd0 : 16'(col + piece);
      count -= piece;
      expected_pieces.push_back(e);
    end
  endtask

  task automatic decode_byte(logic [7:0] b);
    logic [31:0] rgba;
    if (cfg.run_coded && !in_body) begin
      repeat_run = b[7];
      pixels_left = {1'b0, b[6:0]} + 8'd1;
      in_body = 1'b1;
      byte_pos = '0;
      pixel_acc = '0;
      return;
    end
    pixel_acc |= 32'(b) << (8 * byte_pos);
    if (byte_pos < cfg.depth_code) begin
      byte_pos++;
      return;
    end
    rgba = to_rgba(pixel_acc);
    byte_pos = '0;
    pixel_acc = '0;
    if (!cfg.run_coded) begin
      split_run(rgba, 1);
    end else if (repeat_run) begin
      split_run(rgba, pixels_left);
      pixels_left = '0;
      in_body = 1'b0;
    end else begin
      split_run(rgba, 1);
      if (pixels_left > 0) pixels_left--;
      if (pixels_left == 0) in_body = 1'b0;
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (fails < 50) begin
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    end
    fails++;
  endtask

  task automatic compare_piece();
    piece_t e;
    if (expected_pieces.size() == 0) begin
      report("run with nothing expected, length", run_length, 0);
      return;
    end
    e = expected_pieces.pop_front();
    checked++;
    if (red !== e.red) report("red", red, e.red);
    if (green !== e.green) report("green", green, e.green);
    if (blue !== e.blue) report("blue", blue, e.blue);
    if (alpha !== e.alpha) report("alpha", alpha, e.alpha);
    if (run_length !== e.run_length) report("run_length", run_length, e.run_length);
    if (row_end !== e.row_end) report("row_end", row_end, e.row_end);
    if (last !== e.last) report("last", last, e.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.depth_code = RESET_DEPTH;
      cfg.run_coded = RESET_RUN;
      cfg.palette_entries = RESET_PALETTE;
      cfg.image_width = RESET_WIDTH;
      in_body = 1'b0;
      repeat_run = 1'b0;
      pixels_left = '0;
      byte_pos = '0;
      pixel_acc = '0;
      column = '0;
      expected_pieces.delete();
      fails = 0;
      checked = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_DEPTH:   cfg.depth_code = pwdata[1:0];
          REG_RUN:     cfg.run_coded = pwdata[0];
          REG_PALETTE: cfg.palette_entries = pwdata[8:0];
          REG_WIDTH:   cfg.image_width = pwdata[15:0];
          default: ;
        endcase
      end
      if (pop && !empty) compare_piece();
      if (push && !full) begin
        if (mode == MODE_PALETTE) palette_copy[palette_index] = palette_color;
        else decode_byte(data_byte);
      end
    end
    pending = expected_pieces.size();
    aligned = (byte_pos == 0) && (!cfg.run_coded || !in_body);
  end

endmodule

FILE: tb/tga_rle_pixel_decoder_top_test.sv
module tga_rle_pixel_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import trp_pkg::*;

  localparam int ITEM_TARGET = 450;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic        mode = MODE_DATA;
  logic [7:0]  data_byte = '0;
  logic [7:0]  palette_index = '0;
  logic [23:0] palette_color = '0;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [7:0]  run_length;
  logic        row_end;
  logic        last;
  logic        empty;
  logic        pop = 1'b0;

  int          fails;
  int          checked;
  int          pending;
  logic        aligned;

  logic [1:0]  cur_depth = RESET_DEPTH;
  logic        cur_run = RESET_RUN;
  bit          no_gaps = 1'b0;
  bit          random_part = 1'b0;
  bit          hold_done = 1'b0;
  int          items_sent = 0;
  int          phases = 0;

  tga_rle_pixel_decoder_top DUT (.*);

  tga_rle_pixel_decoder_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] pixel_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic send_item(logic m, logic [7:0] b, logic [7:0] idx, logic [23:0] color,
                           int min_gap);
    int gap;
    push <= 1'b1;
    mode <= m;
    data_byte <= b;
    palette_index <= idx;
    palette_color <= color;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap < min_gap) gap = min_gap;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_data(logic [7:0] b);
    send_item(MODE_DATA, b, 8'($urandom), 24'($urandom), 0);
  endtask

  task automatic send_pixel();
    repeat (int'(cur_depth) + 1) send_data(pixel_byte());
  endtask

  task automatic send_packet();
    int count;
    if (!cur_run) begin
      send_pixel();
    end else if ($urandom_range(0, 1) == 0) begin
      count = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 8) : $urandom_range(1, 128);
      send_data({1'b1, 7'(count - 1)});
      send_pixel();
    end else begin
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
      send_data({1'b0, 7'(count - 1)});
      repeat (count) send_pixel();
    end
  endtask

  task automatic cfg_write(logic [1:0] reg_idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (reg_idx == REG_DEPTH) cur_depth = value[1:0];
    if (reg_idx == REG_RUN) cur_run = value[0];
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic realign();
    int tries;
    tries = 0;
    while (!aligned && tries < 40) begin
      send_item(MODE_DATA, pixel_byte(), 8'($urandom), 24'($urandom), 2);
      tries++;
    end
  endtask

  task automatic random_phase();
    int n;
    int r;
    int w;
    drain();
    if ($urandom_range(0, 99) < 60) cfg_write(REG_DEPTH, $urandom_range(0, 3));
    if ($urandom_range(0, 99) < 60) cfg_write(REG_RUN, ($urandom_range(0, 9) < 7) ? 1 : 0);
    if ($urandom_range(0, 99) < 60) begin
      r = $urandom_range(0, 5);
      cfg_write(REG_PALETTE, (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 256
                             : $urandom_range(0, 256));
    end
    if ($urandom_range(0, 99) < 60) begin
      r = $urandom_range(0, 7);
      case (r)
        0: w = MIN_WIDTH;
        1: w = $urandom_range(5, 12);
        2: w = 65535;
        3: w = $urandom_range(4, 65535);
        default: w = $urandom_range(4, 200);
      endcase
      cfg_write(REG_WIDTH, w);
    end
    if ($urandom_range(0, 9) < 8) realign();
    no_gaps = ($urandom_range(0, 3) == 0);
    random_part = 1'b1;
    n = $urandom_range(8, 25);
    repeat (n) begin
      if (items_sent >= ITEM_TARGET) break;
      r = $urandom_range(0, 99);
      if (r < 6) send_item(MODE_PALETTE, 8'($urandom), 8'($urandom), 24'($urandom), 0);
      else if (r < 11) send_data(8'($urandom));
      else send_packet();
    end
    // leave a packet or pixel unfinished across the next setting change
    if ($urandom_range(0, 99) < 30) begin
      if (cur_run) send_data({1'b0, 7'($urandom_range(0, 7))});
      repeat ($urandom_range(0, cur_depth)) send_data(pixel_byte());
    end
    no_gaps = 1'b0;
    phases++;
  endtask

  initial begin
    int r;
    int cycles;
    bit steady;
    cycles = 0;
    steady = 1'b0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles % 200 == 0) steady = ($urandom_range(0, 3) == 0);
      if (random_part && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (!steady && r < 2) begin
          pop <= 1'b0;
          repeat ($urandom_range(8, 40)) @(posedge clk);
        end else begin
          pop <= steady || (r < 75);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PALETTE_DEPTH_DEF; i++) begin
      send_item(MODE_PALETTE, 8'($urandom), 8'(i),
                (i == 0) ? 24'h000000 : (i == 255) ? 24'hFFFFFF : 24'($urandom), 0);
    end

    // reset setting: 24 bit, run-coded, 640 wide
    send_data(8'h80);
    repeat (3) send_data(8'h00);
    repeat (4) send_data(8'hFF);
    drain();

    // column carried into a narrowed row, 128 repeat split at every row end
    cfg_write(REG_WIDTH, MIN_WIDTH);
    cfg_write(REG_DEPTH, DEPTH_32);
    send_data(8'hFF);
    send_data(8'h11);
    send_data(8'h22);
    send_data(8'h33);
    send_data(8'h44);
    send_data(8'h01);
    send_data(8'hA0);
    drain();

    // shrink depth mid-pixel, switch to plain mid-packet
    cfg_write(REG_DEPTH, DEPTH_16);
    cfg_write(REG_RUN, 1'b0);
    send_data(8'hFF);
    send_data(8'h00);
    send_data(8'h80);
    drain();

    // back to packets with the raw packet still open
    cfg_write(REG_RUN, 1'b1);
    send_data(8'h1F);
    send_data(8'h00);
    send_data(8'hE0);
    send_data(8'h03);
    drain();

    cfg_write(REG_DEPTH, DEPTH_8);
    cfg_write(REG_PALETTE, 0);
    send_data(8'h81);
    send_data(8'h7F);
    drain();
    cfg_write(REG_PALETTE, 256);
    send_data(8'h01);
    send_data(8'h00);
    send_data(8'hFF);
    drain();
    cfg_write(REG_PALETTE, 1);
    send_data(8'h01);
    send_data(8'h00);
    send_data(8'h05);
    drain();

    // width below the minimum
    cfg_write(REG_WIDTH, 1);
    send_data(8'h86);
    send_data(8'h00);
    drain();

    // depth drops below the byte position already reached
    cfg_write(REG_WIDTH, 65535);
    cfg_write(REG_DEPTH, DEPTH_32);
    send_data(8'h80);
    send_data(8'h12);
    drain();
    cfg_write(REG_DEPTH, DEPTH_8);
    send_data(8'h34);

    while (items_sent < ITEM_TARGET) random_phase();
    drain();

    $display("%0d items sent over %0d random settings, %0d runs compared", items_sent,
             phases, checked);
    $display("all four depths, plain and run-coded input, palettes and row widths covered");
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
